[design/pfs_pkg.sv]
// shared types, codes and limits of the packet descriptor fifo
package pfs_pkg;

  // command codes
  localparam logic [2:0] CMD_PUT        = 3'd0;
  localparam logic [2:0] CMD_PUT_MARKER = 3'd1;
  localparam logic [2:0] CMD_GET        = 3'd2;
  localparam logic [2:0] CMD_FLUSH      = 3'd3;
  localparam logic [2:0] CMD_START      = 3'd4;
  localparam logic [2:0] CMD_ABORT      = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_ABORTED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_PENDING = 3'd4;

  // defaults of the top level parameters
  localparam int unsigned DEF_QUEUE_DEPTH   = 64;
  localparam int unsigned DEF_NODE_OVERHEAD = 96;

  // running totals
  localparam int unsigned ByteW = 31;
  localparam int unsigned DurW  = 38;
  localparam logic [31:0] BYTE_MAX = 32'h7FFF_FFFF;

  // one stored descriptor
  typedef struct packed {
    logic [31:0] handle;
    logic [23:0] size;
    logic [31:0] duration;
    logic        marker;
    logic [7:0]  stream;
    logic [15:0] serial;
  } entry_t;

  // one result item, entry count kept apart since its width follows the depth
  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     handle;
    logic [23:0]     size;
    logic [31:0]     duration;
    logic [7:0]      stream;
    logic [15:0]     serial;
    logic            marker;
    logic [ByteW-1:0] bytes;
    logic [DurW-1:0] dur_total;
    logic            held;
    logic            last;
  } result_t;

endpackage

[design/pfs_store.sv]
// descriptor memory: one write port, one read port with registered data
module pfs_store #(
  parameter int unsigned Depth = pfs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  pfs_pkg::entry_t wr_entry_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output pfs_pkg::entry_t rd_entry_o
);

  pfs_pkg::entry_t mem_q [Depth];
  pfs_pkg::entry_t rd_entry_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rd_entry_q <= mem_q[rd_idx_i];
  end

  assign rd_entry_o = rd_entry_q;

endmodule

[design/packet_fifo_with_serial.sv]
// packet descriptor fifo with generation serial, top level
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_ready_o | command, packet fields, wait flag
//  out     | output    | out_valid_o / out_ready_i | status, dequeued entry, totals, flags
//
// put, flush, abort and a get that finds the queue empty or aborted are answered from the idle state.
// a get that dequeues passes through S_DEQ, where the head entry comes from the memory read port.
// a put that answers a held get writes the entry, then reads it back through S_HWAIT and S_DEQ.
// an abort that answers a held get gives two result items, the second from S_ABT2.
// after reset the queue is empty and aborted; no clearing pass is needed.
// a stalled output holds its item in the output register and blocks new input.
module packet_fifo_with_serial #(
  parameter int unsigned QUEUE_DEPTH   = pfs_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned NODE_OVERHEAD = pfs_pkg::DEF_NODE_OVERHEAD,
  localparam int unsigned CntW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               command_i,
  input  logic [31:0]              pkt_handle_i,
  input  logic [23:0]              pkt_size_i,
  input  logic [31:0]              pkt_duration_i,
  input  logic [7:0]               stream_index_i,
  input  logic                     wait_if_empty_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic [31:0]              out_handle_o,
  output logic [23:0]              out_size_o,
  output logic [31:0]              out_duration_o,
  output logic [7:0]               out_stream_o,
  output logic [15:0]              out_serial_o,
  output logic                     out_is_marker_o,
  output logic [CntW-1:0]          entry_count_o,
  output logic [pfs_pkg::ByteW-1:0] total_bytes_o,
  output logic [pfs_pkg::DurW-1:0] total_duration_o,
  output logic                     answers_held_get_o,
  output logic                     last_of_run_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);
  localparam logic [31:0]     Overhead = 32'(NODE_OVERHEAD);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HWAIT = 2'd1;
  localparam logic [1:0] S_DEQ   = 2'd2;
  localparam logic [1:0] S_ABT2  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [IdxW-1:0]           head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [pfs_pkg::ByteW-1:0] byte_q, byte_d;
  logic [pfs_pkg::DurW-1:0]  dur_q, dur_d;
  logic [15:0]               serial_q, serial_d;
  logic                      aborted_q, aborted_d;
  logic                      held_q, held_d;
  logic                      deq_held_q, deq_held_d;
  logic                      out_valid_q, out_valid_d;
  pfs_pkg::result_t          out_q, res;
  logic [CntW-1:0]           out_cnt_q;
  logic                      load;

  logic                      slot_free;
  logic                      accept;
  logic                      is_marker;
  logic                      wr_en;
  pfs_pkg::entry_t           wr_entry;
  pfs_pkg::entry_t           rd_entry;
  logic [31:0]               add_x, sub_x, byte_sum;

  // descriptor memory, always reading the head entry
  pfs_store #(
    .Depth (QUEUE_DEPTH),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_idx_i   (tail_q),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (head_q),
    .rd_entry_o (rd_entry)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // entry to be written by a put, a marker put or a start
  assign is_marker = command_i inside {pfs_pkg::CMD_PUT_MARKER, pfs_pkg::CMD_START};
  always_comb begin
    if (is_marker) begin
      wr_entry = '0;
      wr_entry.marker = 1'b1;
      wr_entry.serial = serial_q + 16'd1;
    end else begin
      wr_entry.handle   = pkt_handle_i;
      wr_entry.size     = pkt_size_i;
      wr_entry.duration = pkt_duration_i;
      wr_entry.marker   = 1'b0;
      wr_entry.stream   = stream_index_i;
      wr_entry.serial   = serial_q;
    end
  end

  // byte total arithmetic, saturating on add and flooring on remove
  assign add_x    = {8'd0, wr_entry.size} + Overhead;
  assign sub_x    = {8'd0, rd_entry.size} + Overhead;
  assign byte_sum = {1'b0, byte_q} + add_x;

  // command decode and dequeue sequencing
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    byte_d     = byte_q;
    dur_d      = dur_q;
    serial_d   = serial_q;
    aborted_d  = aborted_q;
    held_d     = held_q;
    deq_held_d = deq_held_q;
    wr_en      = 1'b0;
    load       = 1'b0;
    res        = '0;
    res.status = pfs_pkg::ST_OK;
    res.last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (command_i)
            pfs_pkg::CMD_PUT, pfs_pkg::CMD_PUT_MARKER, pfs_pkg::CMD_START: begin
              if (command_i == pfs_pkg::CMD_START) begin
                aborted_d = 1'b0;
              end
              if (aborted_q && command_i != pfs_pkg::CMD_START) begin
                res.status = pfs_pkg::ST_ABORTED;
              end else if (count_q >= DepthCnt) begin
                res.status = pfs_pkg::ST_FULL;
              end else begin
                wr_en   = 1'b1;
                tail_d  = (tail_q == LastIdx) ? '0 : tail_q + IdxW'(1);
                count_d = count_q + CntW'(1);
                byte_d  = (byte_sum > pfs_pkg::BYTE_MAX) ? pfs_pkg::BYTE_MAX[30:0]
                                                          : byte_sum[30:0];
                dur_d   = dur_q + pfs_pkg::DurW'(wr_entry.duration);
                if (is_marker) begin
                  serial_d = wr_entry.serial;
                end
                if (held_q) begin
                  res.last   = 1'b0;
                  deq_held_d = 1'b1;
                  state_d    = S_HWAIT;
                end
              end
            end
            pfs_pkg::CMD_GET: begin
              if (aborted_q) begin
                res.status = pfs_pkg::ST_ABORTED;
              end else if (count_q != '0) begin
                load       = 1'b0;
                deq_held_d = 1'b0;
                state_d    = S_DEQ;
              end else if (!wait_if_empty_i) begin
                res.status = pfs_pkg::ST_EMPTY;
              end else begin
                held_d     = 1'b1;
                res.status = pfs_pkg::ST_PENDING;
              end
            end
            pfs_pkg::CMD_FLUSH: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              byte_d  = '0;
              dur_d   = '0;
            end
            pfs_pkg::CMD_ABORT: begin
              aborted_d = 1'b1;
              if (held_q) begin
                held_d   = 1'b0;
                res.last = 1'b0;
                state_d  = S_ABT2;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // entry just written, read it back through the head port
      S_HWAIT: begin
        state_d = S_DEQ;
      end
      // head entry data is on the read port
      S_DEQ: begin
        if (slot_free) begin
          load         = 1'b1;
          res.handle   = rd_entry.handle;
          res.size     = rd_entry.size;
          res.duration = rd_entry.duration;
          res.stream   = rd_entry.stream;
          res.serial   = rd_entry.serial;
          res.marker   = rd_entry.marker;
          res.held     = deq_held_q;
          head_d       = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
          count_d      = count_q - CntW'(1);
          byte_d       = ({1'b0, byte_q} < sub_x) ? '0 : byte_q - sub_x[30:0];
          dur_d        = dur_q - pfs_pkg::DurW'(rd_entry.duration);
          if (deq_held_q) begin
            held_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      S_ABT2: begin
        if (slot_free) begin
          load       = 1'b1;
          res.status = pfs_pkg::ST_ABORTED;
          res.held   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.bytes     = byte_d;
    res.dur_total = dur_d;
  end

  // output register valid
  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      byte_q      <= '0;
      dur_q       <= '0;
      serial_q    <= '0;
      aborted_q   <= 1'b1;
      held_q      <= 1'b0;
      deq_held_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      byte_q      <= byte_d;
      dur_q       <= dur_d;
      serial_q    <= serial_d;
      aborted_q   <= aborted_d;
      held_q      <= held_d;
      deq_held_q  <= deq_held_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q     <= res;
      out_cnt_q <= count_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign out_handle_o       = out_q.handle;
  assign out_size_o         = out_q.size;
  assign out_duration_o     = out_q.duration;
  assign out_stream_o       = out_q.stream;
  assign out_serial_o       = out_q.serial;
  assign out_is_marker_o    = out_q.marker;
  assign entry_count_o      = out_cnt_q;
  assign total_bytes_o      = out_q.bytes;
  assign total_duration_o   = out_q.dur_total;
  assign answers_held_get_o = out_q.held;
  assign last_of_run_o      = out_q.last;

  // queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("entry count beyond queue depth");

  // a held get only waits on an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q && state_q == S_IDLE) |-> (count_q == '0))
    else $error("held get with entries queued");

  // an empty queue carries no bytes and no duration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q == '0) |-> (byte_q == '0 && dur_q == '0))
    else $error("totals nonzero on empty queue");

  // a delivered dequeue removes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEQ && slot_free) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("dequeue did not remove one entry");

endmodule

[dv/tb_top.sv]
// self-checking testbench for the packet descriptor fifo with generation serial
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH    = pfs_pkg::DEF_QUEUE_DEPTH;
  localparam int unsigned OVERHEAD = pfs_pkg::DEF_NODE_OVERHEAD;
  localparam int unsigned NUM_ITEMS = 1500;

  // command codes the block does not use
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // table rows either carry a typed status or go to the predictor
  localparam logic PREDICTED = 1'b0;
  localparam logic TYPED     = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] handle;
    logic [23:0] size;
    logic [31:0] duration;
    logic [7:0]  stream;
    logic        hold;
  } stim_t;

  typedef struct packed {
    stim_t      stim;
    logic       typed;
    logic [2:0] exp_status;
  } plan_row_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] handle;
    logic [23:0] size;
    logic [31:0] duration;
    logic [7:0]  stream;
    logic [15:0] serial;
    logic        marker;
    logic [6:0]  count;
    logic [30:0] bytes;
    logic [37:0] dur_total;
    logic        held;
    logic        last;
  } fifo_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  command_i;
  logic [31:0] pkt_handle_i;
  logic [23:0] pkt_size_i;
  logic [31:0] pkt_duration_i;
  logic [7:0]  stream_index_i;
  logic        wait_if_empty_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] out_handle_o;
  logic [23:0] out_size_o;
  logic [31:0] out_duration_o;
  logic [7:0]  out_stream_o;
  logic [15:0] out_serial_o;
  logic        out_is_marker_o;
  logic [6:0]  entry_count_o;
  logic [30:0] total_bytes_o;
  logic [37:0] total_duration_o;
  logic        answers_held_get_o;
  logic        last_of_run_o;

  packet_fifo_with_serial uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .pkt_handle_i       (pkt_handle_i),
    .pkt_size_i         (pkt_size_i),
    .pkt_duration_i     (pkt_duration_i),
    .stream_index_i     (stream_index_i),
    .wait_if_empty_i    (wait_if_empty_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .out_handle_o       (out_handle_o),
    .out_size_o         (out_size_o),
    .out_duration_o     (out_duration_o),
    .out_stream_o       (out_stream_o),
    .out_serial_o       (out_serial_o),
    .out_is_marker_o    (out_is_marker_o),
    .entry_count_o      (entry_count_o),
    .total_bytes_o      (total_bytes_o),
    .total_duration_o   (total_duration_o),
    .answers_held_get_o (answers_held_get_o),
    .last_of_run_o      (last_of_run_o)
  );

  // directed items: reset state, extremes, holds, abort and restart
  plan_row_t directed_plan [26] = '{
    '{'{pfs_pkg::CMD_PUT, 32'h1234_5678, 24'd100, 32'd50, 8'd3, 1'b0},
      TYPED, pfs_pkg::ST_ABORTED},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      TYPED, pfs_pkg::ST_ABORTED},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b1},
      TYPED, pfs_pkg::ST_ABORTED},
    '{'{CMD_SPARE_6, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1},
      TYPED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_ABORT, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      TYPED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_START, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_PUT, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_PUT, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_PUT_MARKER, 32'hDEAD_BEEF, 24'h00_0FFF, 32'h1000, 8'h5A, 1'b1},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      TYPED, pfs_pkg::ST_EMPTY},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b1},
      TYPED, pfs_pkg::ST_PENDING},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b1},
      TYPED, pfs_pkg::ST_PENDING},
    '{'{pfs_pkg::CMD_PUT, 32'hA5A5_A5A5, 24'h5A_5A5A, 32'h0F0F_0F0F, 8'h81, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b1},
      TYPED, pfs_pkg::ST_PENDING},
    '{'{pfs_pkg::CMD_ABORT, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_PUT, 32'h5555_AAAA, 24'd7, 32'd9, 8'd1, 1'b0},
      TYPED, pfs_pkg::ST_ABORTED},
    '{'{pfs_pkg::CMD_START, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b1},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_GET, 32'h0, 24'h0, 32'h0, 8'h0, 1'b1},
      TYPED, pfs_pkg::ST_PENDING},
    '{'{pfs_pkg::CMD_START, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_PUT, 32'h0BAD_F00D, 24'h12_3456, 32'h7FFF_FFFF, 8'h42, 1'b0},
      PREDICTED, pfs_pkg::ST_OK},
    '{'{pfs_pkg::CMD_FLUSH, 32'h0, 24'h0, 32'h0, 8'h0, 1'b0},
      TYPED, pfs_pkg::ST_OK}
  };

  // predictor state
  pfs_pkg::entry_t slot_mem [DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  int unsigned fill;
  logic [30:0] bytes_sum;
  logic [37:0] dur_sum;
  logic [15:0] serial;
  logic        aborted_q;
  logic        held_q;

  fifo_result_t awaited_results [$];
  int unsigned  items_sent;
  int unsigned  results_seen;
  int unsigned  errors;
  logic         idle_en;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // mismatch report
  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // result carrying only status, entry count, running totals and the held flag
  function automatic fifo_result_t totals_only(logic [2:0] st, logic held);
    fifo_result_t r;
    r = '0;
    r.status    = st;
    r.count     = 7'(fill);
    r.bytes     = bytes_sum;
    r.dur_total = dur_sum;
    r.held      = held;
    return r;
  endfunction

  // append one descriptor, byte total saturates
  function automatic void push_entry(pfs_pkg::entry_t e);
    logic [32:0] b;
    slot_mem[tail_pos] = e;
    tail_pos = (tail_pos + 1) % DEPTH;
    fill++;
    b = 33'(bytes_sum) + 33'(e.size) + 33'(OVERHEAD);
    bytes_sum = (b > 33'(pfs_pkg::BYTE_MAX)) ? 31'(pfs_pkg::BYTE_MAX) : b[30:0];
    dur_sum = dur_sum + 38'(e.duration);
  endfunction

  // remove the head descriptor, byte total floors at zero
  function automatic fifo_result_t pop_head(logic held);
    pfs_pkg::entry_t e;
    fifo_result_t    r;
    logic [32:0]     x;
    e = slot_mem[head_pos];
    head_pos = (head_pos + 1) % DEPTH;
    fill--;
    x = 33'(e.size) + 33'(OVERHEAD);
    bytes_sum = (33'(bytes_sum) < x) ? '0 : 31'(33'(bytes_sum) - x);
    dur_sum = dur_sum - 38'(e.duration);
    r = totals_only(pfs_pkg::ST_OK, held);
    r.handle   = e.handle;
    r.size     = e.size;
    r.duration = e.duration;
    r.stream   = e.stream;
    r.serial   = e.serial;
    r.marker   = e.marker;
    return r;
  endfunction

  // advance the predictor by one accepted item and queue what it produces
  function automatic void apply_command(stim_t s, logic typed, logic [2:0] exp_status);
    fifo_result_t    res [2];
    int              n;
    logic            marker;
    pfs_pkg::entry_t e;
    n = 1;
    if (s.cmd inside {pfs_pkg::CMD_PUT, pfs_pkg::CMD_PUT_MARKER, pfs_pkg::CMD_START}) begin
      if (s.cmd == pfs_pkg::CMD_START) aborted_q = 1'b0;
      marker = (s.cmd != pfs_pkg::CMD_PUT);
      if (aborted_q) begin
        res[0] = totals_only(pfs_pkg::ST_ABORTED, 1'b0);
      end else if (fill >= DEPTH) begin
        res[0] = totals_only(pfs_pkg::ST_FULL, 1'b0);
      end else begin
        if (marker) serial = serial + 16'd1;
        e.handle   = marker ? '0 : s.handle;
        e.size     = marker ? '0 : s.size;
        e.duration = marker ? '0 : s.duration;
        e.stream   = marker ? '0 : s.stream;
        e.marker   = marker;
        e.serial   = serial;
        push_entry(e);
        res[0] = totals_only(pfs_pkg::ST_OK, 1'b0);
        // a waiting get takes the new entry right away
        if (held_q) begin
          held_q = 1'b0;
          res[1] = pop_head(1'b1);
          n = 2;
        end
      end
    end else begin
      case (s.cmd)
        pfs_pkg::CMD_GET: begin
          if (aborted_q) begin
            res[0] = totals_only(pfs_pkg::ST_ABORTED, 1'b0);
          end else if (fill > 0) begin
            res[0] = pop_head(1'b0);
          end else if (!s.hold) begin
            res[0] = totals_only(pfs_pkg::ST_EMPTY, 1'b0);
          end else begin
            held_q = 1'b1;
            res[0] = totals_only(pfs_pkg::ST_PENDING, 1'b0);
          end
        end
        pfs_pkg::CMD_FLUSH: begin
          head_pos  = 0;
          tail_pos  = 0;
          fill      = 0;
          bytes_sum = '0;
          dur_sum   = '0;
          res[0] = totals_only(pfs_pkg::ST_OK, 1'b0);
        end
        pfs_pkg::CMD_ABORT: begin
          aborted_q = 1'b1;
          res[0] = totals_only(pfs_pkg::ST_OK, 1'b0);
          if (held_q) begin
            held_q = 1'b0;
            res[1] = totals_only(pfs_pkg::ST_ABORTED, 1'b1);
            n = 2;
          end
        end
        default: begin
          res[0] = totals_only(pfs_pkg::ST_OK, 1'b0);
        end
      endcase
    end
    res[n-1].last = 1'b1;
    // typed rows all leave the queue empty and give one item
    if (typed) begin
      res[0] = '0;
      res[0].status = exp_status;
      res[0].last   = 1'b1;
    end
    for (int i = 0; i < n; i++) awaited_results.push_back(res[i]);
  endfunction

  // random field value, extremes now and then
  function automatic logic [31:0] field_value(int bits);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    return v & 32'((64'd1 << bits) - 64'd1);
  endfunction

  function automatic stim_t rand_stim(logic [2:0] cmd);
    stim_t s;
    s.cmd      = cmd;
    s.handle   = field_value(32);
    s.size     = 24'(field_value(24));
    s.duration = field_value(32);
    s.stream   = 8'(field_value(8));
    s.hold     = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // command mix for free-running stretches
  function automatic logic [2:0] pick_command();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return pfs_pkg::CMD_PUT;
    if (p < 47) return pfs_pkg::CMD_PUT_MARKER;
    if (p < 80) return pfs_pkg::CMD_GET;
    if (p < 83) return pfs_pkg::CMD_FLUSH;
    if (p < 90) return pfs_pkg::CMD_START;
    if (p < 93) return pfs_pkg::CMD_ABORT;
    if (p < 97) return CMD_SPARE_6;
    return CMD_SPARE_7;
  endfunction

  // drive one item and wait for it to be taken
  task automatic drive_item(stim_t s, logic typed, logic [2:0] exp_status);
    int gap;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= s.cmd;
    pkt_handle_i    <= s.handle;
    pkt_size_i      <= s.size;
    pkt_duration_i  <= s.duration;
    stream_index_i  <= s.stream;
    wait_if_empty_i <= s.hold;
    do @(posedge clk_i); while (!in_ready_o);
    apply_command(s, typed, exp_status);
    items_sent++;
  endtask

  task automatic drive_random(logic [2:0] cmd);
    drive_item(rand_stim(cmd), PREDICTED, pfs_pkg::ST_OK);
  endtask

  // output handshake with random stalls
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_en ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    fifo_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("handle", 64'(out_handle_o), 64'(want.handle));
        check_field("size", 64'(out_size_o), 64'(want.size));
        check_field("duration", 64'(out_duration_o), 64'(want.duration));
        check_field("stream", 64'(out_stream_o), 64'(want.stream));
        check_field("serial", 64'(out_serial_o), 64'(want.serial));
        check_field("marker", 64'(out_is_marker_o), 64'(want.marker));
        check_field("entry_count", 64'(entry_count_o), 64'(want.count));
        check_field("total_bytes", 64'(total_bytes_o), 64'(want.bytes));
        check_field("total_duration", 64'(total_duration_o), 64'(want.dur_total));
        check_field("answers_held_get", 64'(answers_held_get_o), 64'(want.held));
        check_field("last_of_run", 64'(last_of_run_o), 64'(want.last));
      end
      results_seen++;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned len;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = pfs_pkg::CMD_PUT;
    pkt_handle_i    = '0;
    pkt_size_i      = '0;
    pkt_duration_i  = '0;
    stream_index_i  = '0;
    wait_if_empty_i = 1'b0;
    idle_en         = 1'b1;
    head_pos        = 0;
    tail_pos        = 0;
    fill            = 0;
    bytes_sum       = '0;
    dur_sum         = '0;
    serial          = '0;
    aborted_q       = 1'b1;
    held_q          = 1'b0;
    items_sent      = 0;
    results_seen    = 0;
    errors          = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (directed_plan[i]) begin
      drive_item(directed_plan[i].stim, directed_plan[i].typed,
                 directed_plan[i].exp_status);
    end

    // random stretches, each with its own idling choice
    while (items_sent < NUM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        // fill to full and push on past it
        4: begin
          if (aborted_q) drive_random(pfs_pkg::CMD_START);
          len = DEPTH - fill + $urandom_range(2, 6);
          repeat (len) begin
            case ($urandom_range(0, 9))
              0:       drive_random(pfs_pkg::CMD_PUT_MARKER);
              1:       drive_random(pfs_pkg::CMD_START);
              default: drive_random(pfs_pkg::CMD_PUT);
            endcase
          end
        end
        // drain and read past empty
        5: begin
          len = fill + $urandom_range(1, 3);
          repeat (len) drive_random(pfs_pkg::CMD_GET);
        end
        // held get on an empty queue, then what answers it
        6: begin
          if (aborted_q) drive_random(pfs_pkg::CMD_START);
          drive_random(pfs_pkg::CMD_FLUSH);
          drive_item('{pfs_pkg::CMD_GET, $urandom, 24'($urandom), $urandom,
                       8'($urandom), 1'b1},
                     PREDICTED, pfs_pkg::ST_OK);
          if ($urandom_range(0, 1) == 1) drive_random(pfs_pkg::CMD_GET);
          case ($urandom_range(0, 3))
            0:       drive_random(pfs_pkg::CMD_PUT_MARKER);
            1:       drive_random(pfs_pkg::CMD_START);
            2:       drive_random(pfs_pkg::CMD_ABORT);
            default: drive_random(pfs_pkg::CMD_PUT);
          endcase
        end
        // abort, items against the aborted queue, restart
        7: begin
          drive_random(pfs_pkg::CMD_ABORT);
          repeat ($urandom_range(1, 5)) drive_random(pick_command());
          drive_random(pfs_pkg::CMD_START);
        end
        default: begin
          repeat ($urandom_range(10, 40)) drive_random(pick_command());
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // let outstanding items come back, then a few more cycles
    for (int i = 0; i < 2000 && awaited_results.size() != 0; i++) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                awaited_results.size()));
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
